### design/gpe_pkg.sv
package gpe_pkg;

    // Fixed geometry of one glyph
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;

    // Field widths
    localparam int COLOR_W  = 16;
    localparam int COORD_W  = 12;
    localparam int ROW_W    = COORD_W + 1;
    localparam int DIM_W    = 11;
    localparam int ROWNUM_W = 4;
    localparam int IDX_W    = 2;
    localparam int PAL_SIZE = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default for the top-level palette storage width
    localparam int COLOR_BITS_DEFAULT = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3    = 3'd5;

    // Reset values of the clip size
    localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 11'd256;

    // Modes
    localparam logic MODE_UNCLIPPED = 1'b0;
    localparam logic MODE_CLIPPED   = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [GLYPH_WIDTH*IDX_W-1:0] row_bits;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic [ROWNUM_W-1:0]        row_number;
    } gpe_item_t;

    typedef struct packed {
        logic signed [ROW_W-1:0]    pixel_row;
        logic signed [COORD_W-1:0]  first_column;
        logic [GLYPH_WIDTH-1:0]     write_mask;
        logic [COLOR_W-1:0]         pixel_color_0;
        logic [COLOR_W-1:0]         pixel_color_1;
        logic [COLOR_W-1:0]         pixel_color_2;
        logic [COLOR_W-1:0]         pixel_color_3;
        logic [COLOR_W-1:0]         pixel_color_4;
        logic [COLOR_W-1:0]         pixel_color_5;
        logic [COLOR_W-1:0]         pixel_color_6;
        logic [COLOR_W-1:0]         pixel_color_7;
    } gpe_result_t;

endpackage

### design/gpe_row_expand.sv
module gpe_row_expand #(
    parameter int COLOR_BITS = gpe_pkg::COLOR_BITS_DEFAULT
) (
    input  gpe_pkg::gpe_item_t                     item,
    input  logic [gpe_pkg::DIM_W-1:0]              image_width,
    input  logic [gpe_pkg::DIM_W-1:0]              image_height,
    input  logic [gpe_pkg::PAL_SIZE-1:0][COLOR_BITS-1:0] palette,
    output gpe_pkg::gpe_result_t                   result
);
    import gpe_pkg::*;

    logic                          clipped;
    logic signed [ROW_W-1:0]       row;
    logic signed [ROW_W-1:0]       height_s;
    logic signed [ROW_W-1:0]       width_s;
    logic                          row_ok;
    logic [GLYPH_WIDTH-1:0]        mask;
    logic [GLYPH_WIDTH-1:0][COLOR_W-1:0] colors;

    assign clipped  = (item.mode == MODE_CLIPPED);
    assign height_s = $signed({2'b00, image_height});
    assign width_s  = $signed({2'b00, image_width});

    // Image row and row-level visibility
    always_comb
    begin
        row = ROW_W'(item.origin_y) + $signed({{(ROW_W-ROWNUM_W){1'b0}}, item.row_number});
        row_ok = ({1'b0, item.row_number} < (ROWNUM_W+1)'(GLYPH_HEIGHT));
        if (clipped && (row < 0 || row >= height_s))
        begin
            row_ok = 1'b0;
        end
    end

    // Per-pixel palette lookup, transparency and column clip
    always_comb
    begin
        logic [IDX_W-1:0]         idx;
        logic [COLOR_BITS-1:0]    color;
        logic signed [ROW_W-1:0]  col;
        logic                     ok;
        for (int k = 0; k < GLYPH_WIDTH; k++)
        begin
            idx   = item.row_bits[(GLYPH_WIDTH-1-k)*IDX_W +: IDX_W];
            color = palette[idx];
            col   = ROW_W'(item.origin_x) + ROW_W'(k);
            ok    = row_ok && (color != '0);
            if (clipped && (col < 0 || col >= width_s))
            begin
                ok = 1'b0;
            end
            mask[k]   = ok;
            colors[k] = ok ? COLOR_W'(color) : '0;
        end
    end

    // Result beat
    always_comb
    begin
        result.pixel_row     = row;
        result.first_column  = item.origin_x;
        result.write_mask    = mask;
        result.pixel_color_0 = colors[0];
        result.pixel_color_1 = colors[1];
        result.pixel_color_2 = colors[2];
        result.pixel_color_3 = colors[3];
        result.pixel_color_4 = colors[4];
        result.pixel_color_5 = colors[5];
        result.pixel_color_6 = colors[6];
        result.pixel_color_7 = colors[7];
    end

endmodule

### design/glyph_row_palette_expander_unit.sv
// Glyph row palette expander.
// Input channel: an item (one glyph row of eight 2-bit palette indices with
// its origin, row number and clip mode) is taken on a clock edge where start
// is high and busy is low. busy stays low, so an item can be started every
// cycle.
// Result channel: result_valid is high for exactly one cycle with the result
// beat (image row, first column, write mask, eight colors). The receiver
// cannot stall; every result must be taken in the cycle it is shown.
// Path: the item is captured in the input register, expanded combinationally,
// then captured in the result register, from which the result is shown.
// Throughput: one item per cycle, set by the single combinational expansion
// stage between the two registers.
// Configuration: cfg_write/cfg_index/cfg_data write the clip size and the
// four palette colors; writes are taken at once and should only happen when
// no item is in flight. Unknown indexes are ignored.
// Reset: clears the valid flags, sets the clip size to 256 x 256 and all
// palette colors to zero (transparent).
module glyph_row_palette_expander_unit #(
    parameter int COLOR_BITS = gpe_pkg::COLOR_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gpe_pkg::gpe_item_t                item,
    output logic                              result_valid,
    output gpe_pkg::gpe_result_t              result,
    input  logic                              cfg_write,
    input  logic [gpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gpe_pkg::*;

    logic [DIM_W-1:0]                      width_reg;
    logic [DIM_W-1:0]                      height_reg;
    logic [PAL_SIZE-1:0][COLOR_BITS-1:0]   palette_reg;

    gpe_item_t                             item_reg;
    logic                                  item_valid_reg;
    gpe_result_t                           result_reg;
    logic                                  result_valid_reg;
    gpe_result_t                           result_next;

    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= IMAGE_DIM_RESET;
            height_reg  <= IMAGE_DIM_RESET;
            palette_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg      <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg     <= cfg_data[DIM_W-1:0];
                REG_PALETTE_0:    palette_reg[0] <= COLOR_BITS'(cfg_data);
                REG_PALETTE_1:    palette_reg[1] <= COLOR_BITS'(cfg_data);
                REG_PALETTE_2:    palette_reg[2] <= COLOR_BITS'(cfg_data);
                REG_PALETTE_3:    palette_reg[3] <= COLOR_BITS'(cfg_data);
                default:          ;
            endcase
        end
    end

    // Valid flags for the input and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= start && !busy;
            result_valid_reg <= item_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        if (item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    gpe_row_expand #(
        .COLOR_BITS (COLOR_BITS)
    ) u_expand (
        .item         (item_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .palette      (palette_reg),
        .result       (result_next)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
